// ----- rtl/core/apq_pkg.sv -----
// ----------------------------------------------------------------------------
// apq_pkg
// Types, codes and limits shared by the aging priority queue.
// ----------------------------------------------------------------------------
package apq_pkg;

  localparam int Depth   = 16;
  localparam int IdMax   = 255;
  localparam int PrioMax = 15;

  localparam int IdW   = 8;
  localparam int PrioW = 4;
  localparam int OccW  = 5;

  typedef enum logic [1:0] {
    OpInsert   = 2'd0,
    OpRetrieve = 2'd1,
    OpClose    = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    StOk     = 3'd0,
    StFull   = 3'd1,
    StEmpty  = 3'd2,
    StClosed = 3'd3,
    StBadArg = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]       operation;
    logic [IdW-1:0]   entry_id;
    logic [PrioW-1:0] entry_priority;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]      status;
    logic [IdW-1:0]  removed_id;
    logic [OccW-1:0] occupancy;
  } out_beat_t;

  typedef struct packed {
    logic             valid;
    logic [IdW-1:0]   id;
    logic [PrioW-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic             ins;
    logic             ret;
    logic [IdW-1:0]   id;
    logic [PrioW-1:0] prio;
  } cell_cmd_t;

endpackage

// ----- rtl/core/apq_cell.sv -----
// ----------------------------------------------------------------------------
// apq_cell
// One queue position: holds, shifts right on insert, shifts left and ages
// on retrieve.
// ----------------------------------------------------------------------------
module apq_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  apq_pkg::cell_cmd_t cmd_i,
  input  apq_pkg::entry_t    left_i,
  input  apq_pkg::entry_t    right_i,
  input  logic               left_take_i,
  output apq_pkg::entry_t    entry_o,
  output logic               take_o
);

  apq_pkg::entry_t entry_q, entry_d;

  assign entry_o = entry_q;
  assign take_o  = !entry_q.valid || (entry_q.prio > cmd_i.prio);

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.ins) begin
      if (left_take_i) begin
        entry_d = left_i;
      end else if (take_o) begin
        entry_d.valid = 1'b1;
        entry_d.id    = cmd_i.id;
        entry_d.prio  = cmd_i.prio;
      end
    end else if (cmd_i.ret) begin
      entry_d = right_i;
      if (right_i.prio > apq_pkg::PrioW'(1)) begin
        entry_d.prio = right_i.prio - apq_pkg::PrioW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

endmodule

// ----- rtl/core/aging_priority_queue_unit.sv -----
// ----------------------------------------------------------------------------
// aging_priority_queue_unit
// Sorted queue kept in a chain of cells; head is cell 0.
// Each result beat is registered and appears in the cycle after its input beat is accepted.
// Throughput: one beat per cycle while the output is not stalled; every cell updates in parallel each beat.
// Reset: queue empty and open, no result pending.
// ----------------------------------------------------------------------------
module aging_priority_queue_unit #(
  parameter int DEPTH = apq_pkg::Depth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  apq_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output apq_pkg::out_beat_t out_data_o
);

  localparam int CntW = $clog2(DEPTH + 1);

  apq_pkg::entry_t    entries [DEPTH];
  logic [DEPTH-1:0]   takes;
  apq_pkg::cell_cmd_t cmd;

  logic [CntW-1:0]    count_q, count_d;
  logic               closed_q, closed_d;
  logic               out_valid_q;
  apq_pkg::out_beat_t out_q, out_d;
  logic               accept;
  apq_pkg::status_e   status;
  logic               bad_ins;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign bad_ins = (32'(in_data_i.entry_id) > apq_pkg::IdMax)
                || (in_data_i.entry_priority == '0)
                || (32'(in_data_i.entry_priority) > apq_pkg::PrioMax);

  always_comb begin
    status   = apq_pkg::StOk;
    closed_d = closed_q;
    count_d  = count_q;
    cmd.ins  = 1'b0;
    cmd.ret  = 1'b0;
    cmd.id   = in_data_i.entry_id;
    cmd.prio = in_data_i.entry_priority;
    unique case (in_data_i.operation)
      apq_pkg::OpInsert: begin
        if (bad_ins) begin
          status = apq_pkg::StBadArg;
        end else if (closed_q) begin
          status = apq_pkg::StClosed;
        end else if (count_q >= CntW'(DEPTH)) begin
          status = apq_pkg::StFull;
        end else begin
          cmd.ins = accept;
          count_d = count_q + CntW'(1);
        end
      end
      apq_pkg::OpRetrieve: begin
        if (closed_q) begin
          status = apq_pkg::StClosed;
        end else if (count_q == '0) begin
          status = apq_pkg::StEmpty;
        end else begin
          cmd.ret = accept;
          count_d = count_q - CntW'(1);
        end
      end
      apq_pkg::OpClose: begin
        if (closed_q) begin
          status = apq_pkg::StClosed;
        end else begin
          closed_d = 1'b1;
        end
      end
      default: begin
        status = apq_pkg::StBadArg;
      end
    endcase
    out_d.status     = status;
    out_d.removed_id = (in_data_i.operation == apq_pkg::OpRetrieve
                        && status == apq_pkg::StOk) ? entries[0].id : '0;
    out_d.occupancy  = apq_pkg::OccW'(count_d);
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    apq_pkg::entry_t left, right;
    logic            left_take;
    if (k == 0) begin : g_first
      assign left      = '0;
      assign left_take = 1'b0;
    end else begin : g_mid
      assign left      = entries[k-1];
      assign left_take = takes[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_next
      assign right = entries[k+1];
    end
    apq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .left_i      (left),
      .right_i     (right),
      .left_take_i (left_take),
      .entry_o     (entries[k]),
      .take_o      (takes[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      closed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q  <= count_d;
        closed_q <= closed_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the aging priority queue. Beats are driven with
// random idle gaps on both sides. An in-bench sorted-list predictor computes
// status, removed id and occupancy for every accepted request, and each
// result beat is checked against the oldest prediction. Directed corners
// come first, then shaped random traffic, a long output stall, and the
// close sequence last, since a closed queue stays closed.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OpUnknown  = 2'd3;
  localparam int         StallLimit = 2000;
  localparam int         MaxReports = 10;

  typedef struct {
    logic [apq_pkg::IdW-1:0]   id;
    logic [apq_pkg::PrioW-1:0] prio;
  } slot_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready_o;
  apq_pkg::in_beat_t  in_data = '0;
  logic               out_valid_o;
  logic               out_ready = 1'b0;
  apq_pkg::out_beat_t out_data_o;

  slot_t              held_entries[$];
  bit                 queue_closed = 1'b0;
  apq_pkg::out_beat_t pending_results[$];
  apq_pkg::out_beat_t expd;
  int                 mismatches = 0;
  int                 stall_cycles = 0;
  int                 rx_hold_req = 0;
  bit                 tx_idle_en = 1'b1;
  bit                 rx_idle_en = 1'b1;

  aging_priority_queue_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_data_o (out_data_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic apq_pkg::out_beat_t queue_apply(apq_pkg::in_beat_t req);
    apq_pkg::out_beat_t res;
    slot_t              s;
    int                 pos;
    res = '0;
    case (req.operation)
      apq_pkg::OpInsert: begin
        if (req.entry_priority == 0 || req.entry_id > apq_pkg::IdMax
            || req.entry_priority > apq_pkg::PrioMax) begin
          res.status = apq_pkg::StBadArg;
        end else if (queue_closed) begin
          res.status = apq_pkg::StClosed;
        end else if (held_entries.size() >= apq_pkg::Depth) begin
          res.status = apq_pkg::StFull;
        end else begin
          pos = held_entries.size();
          while (pos > 0 && held_entries[pos-1].prio > req.entry_priority) pos--;
          s.id   = req.entry_id;
          s.prio = req.entry_priority;
          held_entries.insert(pos, s);
          res.status = apq_pkg::StOk;
        end
      end
      apq_pkg::OpRetrieve: begin
        if (queue_closed) begin
          res.status = apq_pkg::StClosed;
        end else if (held_entries.size() == 0) begin
          res.status = apq_pkg::StEmpty;
        end else begin
          res.removed_id = held_entries[0].id;
          void'(held_entries.pop_front());
          foreach (held_entries[i]) begin
            if (held_entries[i].prio > 1) held_entries[i].prio = held_entries[i].prio - 1'b1;
          end
          res.status = apq_pkg::StOk;
        end
      end
      apq_pkg::OpClose: begin
        if (queue_closed) begin
          res.status = apq_pkg::StClosed;
        end else begin
          queue_closed = 1'b1;
          res.status = apq_pkg::StOk;
        end
      end
      default: res.status = apq_pkg::StBadArg;
    endcase
    res.occupancy = apq_pkg::OccW'(held_entries.size());
    return res;
  endfunction

  task automatic note_mismatch(string what, apq_pkg::out_beat_t want,
                               apq_pkg::out_beat_t got);
    mismatches++;
    if (mismatches <= MaxReports) begin
      $display("%0t: %s: expected status %0d id %0d occ %0d, got status %0d id %0d occ %0d",
               $time, what, want.status, want.removed_id, want.occupancy,
               got.status, got.removed_id, got.occupancy);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready_o) pending_results.push_back(queue_apply(in_data));
      if (out_valid_o && out_ready) begin
        if (pending_results.size() == 0) begin
          note_mismatch("unexpected beat", '0, out_data_o);
        end else begin
          expd = pending_results.pop_front();
          if (out_data_o.status !== expd.status || out_data_o.removed_id !== expd.removed_id ||
              out_data_o.occupancy !== expd.occupancy) begin
            note_mismatch("result mismatch", expd, out_data_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : rx_side
    int gap;
    int hold_cnt;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (rx_hold_req > 0) begin
        out_ready <= 1'b0;
        for (hold_cnt = 0; hold_cnt < rx_hold_req; hold_cnt++) @(negedge clk_i);
        rx_hold_req = 0;
      end
      gap = rx_idle_en ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  task automatic send_request(logic [1:0] op, logic [apq_pkg::IdW-1:0] id,
                              logic [apq_pkg::PrioW-1:0] prio);
    int                gap;
    apq_pkg::in_beat_t req;
    req.operation      = op;
    req.entry_id       = id;
    req.entry_priority = prio;
    gap = tx_idle_en ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic test_reset_corners();
    send_request(apq_pkg::OpRetrieve, apq_pkg::IdW'(apq_pkg::IdMax),
                 apq_pkg::PrioW'(apq_pkg::PrioMax));
    send_request(OpUnknown, apq_pkg::IdW'(apq_pkg::IdMax), apq_pkg::PrioW'(apq_pkg::PrioMax));
    send_request(apq_pkg::OpInsert, apq_pkg::IdW'(apq_pkg::IdMax), '0);
    wait_idle();
  endtask

  task automatic test_fill_and_age();
    for (int i = 0; i < apq_pkg::Depth; i++) begin
      send_request(apq_pkg::OpInsert, apq_pkg::IdW'(i * 17),
                   apq_pkg::PrioW'((i * 7) % apq_pkg::PrioMax + 1));
    end
    send_request(apq_pkg::OpInsert, 8'h5a, 4'd1);
    send_request(apq_pkg::OpRetrieve, '0, '0);
    send_request(apq_pkg::OpRetrieve, '0, '0);
    send_request(apq_pkg::OpInsert, 8'ha5, 4'd1);
    send_request(apq_pkg::OpRetrieve, '0, '0);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int                        done_cnt;
    int                        burst;
    int                        insert_pct;
    int                        roll;
    logic [apq_pkg::PrioW-1:0] top_prio;
    done_cnt = 0;
    while (done_cnt < 1700) begin
      burst = $urandom_range(8, 60);
      case ($urandom_range(0, 2))
        0:       insert_pct = 80;
        1:       insert_pct = 25;
        default: insert_pct = 50;
      endcase
      top_prio   = ($urandom_range(0, 1) == 1) ? apq_pkg::PrioW'(apq_pkg::PrioMax)
                                               : apq_pkg::PrioW'(3);
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      repeat (burst) begin
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          send_request(OpUnknown, apq_pkg::IdW'($urandom_range(0, apq_pkg::IdMax)),
                       apq_pkg::PrioW'($urandom_range(0, apq_pkg::PrioMax)));
        end else if (roll < 6) begin
          send_request(apq_pkg::OpInsert, apq_pkg::IdW'($urandom_range(0, apq_pkg::IdMax)),
                       '0);
        end else if ($urandom_range(0, 99) < insert_pct) begin
          send_request(apq_pkg::OpInsert, apq_pkg::IdW'($urandom_range(0, apq_pkg::IdMax)),
                       apq_pkg::PrioW'($urandom_range(1, top_prio)));
        end else begin
          send_request(apq_pkg::OpRetrieve, apq_pkg::IdW'($urandom_range(0, apq_pkg::IdMax)),
                       apq_pkg::PrioW'($urandom_range(0, apq_pkg::PrioMax)));
        end
        done_cnt++;
      end
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    wait_idle();
  endtask

  task automatic test_output_stall();
    tx_idle_en  = 1'b0;
    rx_hold_req = 300;
    for (int i = 0; i < 30; i++) begin
      if (i % 3 == 2) begin
        send_request(apq_pkg::OpRetrieve, '0, '0);
      end else begin
        send_request(apq_pkg::OpInsert, apq_pkg::IdW'($urandom_range(0, apq_pkg::IdMax)),
                     apq_pkg::PrioW'($urandom_range(1, apq_pkg::PrioMax)));
      end
    end
    tx_idle_en = 1'b1;
    wait_idle();
  endtask

  task automatic test_close();
    send_request(apq_pkg::OpInsert, 8'h11, 4'd4);
    send_request(apq_pkg::OpClose, '0, '0);
    send_request(apq_pkg::OpClose, '0, '0);
    send_request(apq_pkg::OpInsert, 8'h22, 4'd5);
    send_request(apq_pkg::OpInsert, 8'h33, '0);
    send_request(apq_pkg::OpRetrieve, '0, '0);
    send_request(OpUnknown, '0, '0);
    wait_idle();
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_corners();
    test_fill_and_age();
    test_random_traffic();
    test_output_stall();
    test_close();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/apq_pkg.sv
rtl/core/apq_cell.sv
rtl/core/aging_priority_queue_unit.sv
tb/sv/tb_top.sv
